[sv/ytv_pkg.sv]
package ytv_pkg;

  localparam int FracBits = 16;
  localparam int DW = 32;
  localparam int IW = 48;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPEED,
    ST_V2,
    ST_KV2,
    ST_DEN,
    ST_DIV1,
    ST_ERR,
    ST_INTEG,
    ST_DIV2,
    ST_PTERM,
    ST_ITERM,
    ST_ITERM_HI,
    ST_DTERM,
    ST_SPLIT,
    ST_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic speed;
    logic v2;
    logic kv2;
    logic den;
    logic div1_start;
    logic err;
    logic integ;
    logic div2_start;
    logic pterm;
    logic iterm;
    logic iterm_hi;
    logic dterm;
    logic split;
    logic inactive;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic div_done;
  } sts_t;

  localparam int CfgKp = 0;
  localparam int CfgKi = 1;
  localparam int CfgKd = 2;
  localparam int CfgMax = 3;
  localparam int CfgWb = 4;
  localparam int CfgKu = 5;
  localparam int CfgScale = 6;
  localparam int CfgEn = 7;

endpackage

[sv/yaw_rate_torque_vectoring_pid_top.sv]
// yaw-rate torque vectoring: speed from wheel speed, bicycle-model desired yaw rate,
// pid on yaw error, delta clamped and split across axles. one beat in, one beat out;
// an active beat runs two 80-step serial divisions (desired rate and derivative, each
// with start and done) on one shared divider, and all its products but the division
// numerator go through one 32x32 multiplier; an inactive beat skips the divisions; a
// stalled receiver holds the result until it is taken
module yaw_rate_torque_vectoring_pid_top #(
  parameter int FRAC_BITS = ytv_pkg::FracBits
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_torque_command,
  input  logic signed [31:0] in_wheel_speed,
  input  logic signed [31:0] in_steering_angle,
  input  logic signed [31:0] in_measured_yaw_rate,
  input  logic [30:0]        in_step_dt,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_left_axle_torque,
  output logic signed [31:0] out_right_axle_torque,
  output logic signed [31:0] out_torque_delta,
  output logic               out_vectoring_active,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  logic signed [31:0] kp_r, ki_r, kd_r, ku_r;
  logic [30:0]        max_r, wb_r, scale_r;
  logic               en_r;
  ytv_pkg::cmd_t      cmd;
  ytv_pkg::sts_t      sts;

  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= 32'sd65536; ki_r <= '0; kd_r <= '0; max_r <= 31'd262144;
      wb_r <= 31'd99484; ku_r <= '0; scale_r <= 31'd1964; en_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (32'(cfg_index))
        ytv_pkg::CfgKp:    kp_r <= cfg_data;
        ytv_pkg::CfgKi:    ki_r <= cfg_data;
        ytv_pkg::CfgKd:    kd_r <= cfg_data;
        ytv_pkg::CfgMax:   max_r <= cfg_data[30:0];
        ytv_pkg::CfgWb:    wb_r <= cfg_data[30:0];
        ytv_pkg::CfgKu:    ku_r <= cfg_data;
        ytv_pkg::CfgScale: scale_r <= cfg_data[30:0];
        ytv_pkg::CfgEn:    en_r <= cfg_data[0];
        default:           en_r <= en_r;
      endcase
    end
  end

  ytv_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  ytv_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .torque_command(in_torque_command), .wheel_speed(in_wheel_speed),
    .steering_angle(in_steering_angle), .measured_yaw_rate(in_measured_yaw_rate),
    .step_dt(in_step_dt),
    .kp_gain(kp_r), .ki_gain(ki_r), .kd_gain(kd_r), .max_delta(max_r),
    .wheelbase(wb_r), .understeer_gradient(ku_r), .speed_scale(scale_r),
    .vectoring_enable(en_r),
    .left_axle_torque(out_left_axle_torque), .right_axle_torque(out_right_axle_torque),
    .torque_delta(out_torque_delta), .vectoring_active(out_vectoring_active)
  );
endmodule

[sv/ytv_div.sv]
// signed restoring divider, truncates toward zero, one quotient bit per cycle
// quotient is held from the cycle done is high until the next start
module ytv_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [79:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [80:0] quo
);
  logic [79:0] q_r, q_nxt;
  logic [80:0] rem_r, rem_nxt;
  logic [31:0] d_r;
  logic        neg_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [80:0] trial;

  always_comb begin
    trial = {rem_r[79:0], q_r[79]} - {49'd0, d_r};
    if (!trial[80]) begin
      rem_nxt = trial;
      q_nxt = {q_r[78:0], 1'b1};
    end else begin
      rem_nxt = {rem_r[79:0], q_r[79]};
      q_nxt = {q_r[78:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == 7'd1);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 7'd80;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) busy_r <= 1'b0;
      end
    end
    if (start) begin
      q_r <= num[79] ? 80'(-num) : 80'(num);
      d_r <= den[31] ? 32'(-den) : 32'(den);
      neg_r <= num[79] ^ den[31];
      rem_r <= '0;
    end else if (busy_r) begin
      q_r <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
endmodule

[sv/ytv_dp.sv]
module ytv_dp #(
  parameter int FRAC_BITS = ytv_pkg::FracBits
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ytv_pkg::cmd_t       cmd,
  output ytv_pkg::sts_t       sts,
  input  logic signed [31:0]  torque_command,
  input  logic signed [31:0]  wheel_speed,
  input  logic signed [31:0]  steering_angle,
  input  logic signed [31:0]  measured_yaw_rate,
  input  logic [30:0]         step_dt,
  input  logic signed [31:0]  kp_gain,
  input  logic signed [31:0]  ki_gain,
  input  logic signed [31:0]  kd_gain,
  input  logic [30:0]         max_delta,
  input  logic [30:0]         wheelbase,
  input  logic signed [31:0]  understeer_gradient,
  input  logic [30:0]         speed_scale,
  input  logic                vectoring_enable,
  output logic signed [31:0]  left_axle_torque,
  output logic signed [31:0]  right_axle_torque,
  output logic signed [31:0]  torque_delta,
  output logic                vectoring_active
);
  localparam logic signed [63:0] One = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] Eps = One / 10000;
  localparam logic signed [63:0] Vmin = 5 * One;

  logic signed [31:0] cmd_r, ws_r, steer_r, yaw_r;
  logic [30:0]        dt_r;
  logic signed [31:0] v_r, v2_r, kv2_r, den_r, err_r, diff_r, prev_r;
  logic signed [47:0] integ_r;
  logic signed [63:0] acc_r;
  logic signed [63:0] ilo_r;
  logic               small_r;

  // shared 32 x 32 multiplier except the divide numerator; 48-bit integral in two parts
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [95:0] mwide;
  logic signed [95:0] prod_sh;
  logic signed [31:0] prod_sat;
  logic               div_start, div_done;
  logic signed [79:0] div_num;
  logic signed [31:0] div_den;
  logic signed [80:0] div_quo;
  logic signed [31:0] quo_sat;
  logic signed [63:0] isum;
  logic signed [63:0] sum_c;
  logic signed [63:0] lim;
  logic signed [31:0] half;
  logic signed [32:0] l_w, r_w;

  function automatic logic signed [31:0] sat32(input logic signed [95:0] x);
    if (x > 96'sd2147483647) return 32'sh7fffffff;
    if (x < -96'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  always_comb begin
    ma = '0;
    mb = '0;
    if (cmd.speed) begin
      ma = ws_r; mb = $signed({1'b0, speed_scale});
    end else if (cmd.v2) begin
      ma = v_r; mb = v_r;
    end else if (cmd.kv2) begin
      ma = understeer_gradient; mb = v2_r;
    end else if (cmd.integ) begin
      ma = err_r; mb = $signed({1'b0, dt_r});
    end else if (cmd.pterm) begin
      ma = kp_gain; mb = err_r;
    end else if (cmd.iterm) begin
      ma = ki_gain; mb = 32'($signed({1'b0, integ_r[15:0]}));
    end else if (cmd.iterm_hi) begin
      ma = ki_gain; mb = $signed(integ_r[47:16]);
    end else if (cmd.dterm) begin
      ma = kd_gain; mb = diff_r;
    end
    prod = 64'(ma) * 64'(mb);
    // upper half of the integral product joins the lower half kept from the cycle before
    mwide = cmd.iterm_hi ? (96'(prod) <<< 16) + 96'(ilo_r) : 96'(prod);
    prod_sh = mwide >>> FRAC_BITS;
    prod_sat = sat32(prod_sh);
  end

  assign div_start = cmd.div1_start | cmd.div2_start;
  assign div_num = cmd.div1_start ? 80'(64'(v_r) * 64'(steer_r))
                                  : 80'(64'(64'(err_r) - 64'(prev_r)) <<< FRAC_BITS);
  assign div_den = cmd.div1_start ? den_r : $signed({1'b0, dt_r});

  ytv_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  assign quo_sat = sat32(96'(div_quo));
  assign isum = 64'(integ_r) + 64'(prod_sh[63:0]);
  assign lim = 64'($signed({1'b0, max_delta}));
  assign sum_c = (acc_r > lim) ? lim : ((acc_r < -lim) ? -lim : acc_r);
  assign half = 32'(sum_c / 2);
  assign l_w = 33'(cmd_r) - 33'(half);
  assign r_w = 33'(cmd_r) + 33'(half);

  assign sts.active = vectoring_enable && (64'(v_r) > Vmin);
  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      prev_r <= '0;
    end else begin
      if (cmd.integ) begin
        if (isum > 64'sh7fffffffffff) integ_r <= 48'sh7fffffffffff;
        else if (isum < -64'sh800000000000) integ_r <= 48'sh800000000000;
        else integ_r <= isum[47:0];
      end
      if (cmd.split) prev_r <= err_r;
    end
    if (cmd.load) begin
      cmd_r <= torque_command;
      ws_r <= wheel_speed;
      steer_r <= steering_angle;
      yaw_r <= measured_yaw_rate;
      dt_r <= step_dt;
    end
    if (cmd.speed) v_r <= prod_sat;
    if (cmd.v2) v2_r <= prod_sat;
    if (cmd.kv2) kv2_r <= prod_sat;
    if (cmd.den) begin
      den_r <= sat32(96'($signed({1'b0, wheelbase})) + 96'(kv2_r));
      small_r <= 1'b0;
    end
    if (cmd.div1_start) small_r <= (den_r < 0 ? -64'(den_r) : 64'(den_r)) <= Eps;
    if (cmd.err) err_r <= sat32(96'(small_r ? 32'sd0 : quo_sat) - 96'(yaw_r));
    // zero elapsed time leaves the derivative at zero
    if (cmd.div2_start) diff_r <= '0;
    else if (div_done && dt_r != '0) diff_r <= quo_sat;
    if (cmd.iterm) ilo_r <= prod;
    if (cmd.pterm) acc_r <= 64'(prod_sat);
    if (cmd.iterm_hi || cmd.dterm) acc_r <= acc_r + 64'(prod_sat);
    if (cmd.split) begin
      left_axle_torque <= sat32(96'(l_w));
      right_axle_torque <= sat32(96'(r_w));
      torque_delta <= sum_c[31:0];
      vectoring_active <= 1'b1;
    end
    if (cmd.inactive) begin
      left_axle_torque <= cmd_r;
      right_axle_torque <= cmd_r;
      torque_delta <= '0;
      vectoring_active <= 1'b0;
    end
  end
endmodule

[sv/ytv_ctrl.sv]
module ytv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ytv_pkg::sts_t     sts,
  output ytv_pkg::cmd_t     cmd
);
  ytv_pkg::state_t state_r, state_nxt;
  logic            div_seen_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ytv_pkg::ST_IDLE:     if (in_valid) state_nxt = ytv_pkg::ST_SPEED;
      ytv_pkg::ST_SPEED:    state_nxt = ytv_pkg::ST_V2;
      ytv_pkg::ST_V2:       state_nxt = sts.active ? ytv_pkg::ST_KV2 : ytv_pkg::ST_OUT;
      ytv_pkg::ST_KV2:      state_nxt = ytv_pkg::ST_DEN;
      ytv_pkg::ST_DEN:      state_nxt = ytv_pkg::ST_DIV1;
      ytv_pkg::ST_DIV1:     if (sts.div_done) state_nxt = ytv_pkg::ST_ERR;
      ytv_pkg::ST_ERR:      state_nxt = ytv_pkg::ST_INTEG;
      ytv_pkg::ST_INTEG:    state_nxt = ytv_pkg::ST_DIV2;
      ytv_pkg::ST_DIV2:     if (sts.div_done) state_nxt = ytv_pkg::ST_PTERM;
      ytv_pkg::ST_PTERM:    state_nxt = ytv_pkg::ST_ITERM;
      ytv_pkg::ST_ITERM:    state_nxt = ytv_pkg::ST_ITERM_HI;
      ytv_pkg::ST_ITERM_HI: state_nxt = ytv_pkg::ST_DTERM;
      ytv_pkg::ST_DTERM:    state_nxt = ytv_pkg::ST_SPLIT;
      ytv_pkg::ST_SPLIT:    state_nxt = ytv_pkg::ST_OUT;
      ytv_pkg::ST_OUT:      if (out_ready) state_nxt = ytv_pkg::ST_IDLE;
      default:              state_nxt = ytv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ytv_pkg::ST_IDLE:     begin in_ready = 1'b1; cmd.load = in_valid; end
      ytv_pkg::ST_SPEED:    cmd.speed = 1'b1;
      ytv_pkg::ST_V2:       begin cmd.v2 = 1'b1; cmd.inactive = !sts.active; end
      ytv_pkg::ST_KV2:      cmd.kv2 = 1'b1;
      ytv_pkg::ST_DEN:      cmd.den = 1'b1;
      ytv_pkg::ST_DIV1:     cmd.div1_start = !div_seen_r;
      ytv_pkg::ST_ERR:      cmd.err = 1'b1;
      ytv_pkg::ST_INTEG:    cmd.integ = 1'b1;
      ytv_pkg::ST_DIV2:     cmd.div2_start = !div_seen_r;
      ytv_pkg::ST_PTERM:    cmd.pterm = 1'b1;
      ytv_pkg::ST_ITERM:    cmd.iterm = 1'b1;
      ytv_pkg::ST_ITERM_HI: cmd.iterm_hi = 1'b1;
      ytv_pkg::ST_DTERM:    cmd.dterm = 1'b1;
      ytv_pkg::ST_SPLIT:    cmd.split = 1'b1;
      ytv_pkg::ST_OUT:      out_valid = 1'b1;
      default:              cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ytv_pkg::ST_IDLE;
      div_seen_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      div_seen_r <= (state_nxt == ytv_pkg::ST_DIV1 || state_nxt == ytv_pkg::ST_DIV2)
                    && (state_nxt == state_r);
    end
  end

  a_one_hot_mul: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.speed, cmd.v2, cmd.kv2, cmd.integ, cmd.pterm, cmd.iterm, cmd.iterm_hi,
              cmd.dterm}))
    else $error("multiplier claimed twice");
  a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("accept while result pending");
  a_split_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.split |=> out_valid) else $error("result not presented");
endmodule
